// ===== hw/rtl/board_io_register_slave_top_defines.svh =====
// Assertion macros used by the checker file.
`ifndef BOARD_IO_REGISTER_SLAVE_TOP_DEFINES_SVH
`define BOARD_IO_REGISTER_SLAVE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BIOR_AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bior check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BIOR_AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bior check failed");

`endif

// ===== hw/rtl/bior_pkg.sv =====
// Types and constants of the board I/O register slave.
package bior_pkg;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_READ   = 2'd1,
    OP_WRITE  = 2'd2
  } op_t;

  // bus register map
  localparam logic [7:0] ADDR_VERSION  = 8'h00;
  localparam logic [7:0] ADDR_PWR_BTN  = 8'h01;
  localparam logic [7:0] ADDR_CHG_FLAG = 8'h02;
  localparam logic [7:0] ADDR_TCH_BTN  = 8'h03;
  localparam logic [7:0] ADDR_SPEAKER  = 8'h04;
  localparam logic [7:0] ADDR_TCH_RST  = 8'h05;
  localparam logic [7:0] ADDR_BKLIGHT  = 8'h06;
  localparam logic [7:0] ADDR_LCD_CMD  = 8'h07;
  localparam logic [7:0] ADDR_LCD_DATA = 8'h08;
  localparam logic [7:0] ADDR_PWM_DUTY = 8'h09;
  localparam logic [7:0] ADDR_ADC_LAT  = 8'h0A;
  localparam logic [7:0] ADDR_ADC_LO   = 8'h0B;
  localparam logic [7:0] ADDR_ADC_HI   = 8'h0C;

  // configuration register indexes
  localparam int unsigned CFG_AW = 4;
  localparam logic [1:0] CFG_IDX_VERSION = 2'd0;
  localparam logic [1:0] CFG_IDX_WINDOW  = 2'd1;
  localparam logic [1:0] CFG_IDX_LIMIT   = 2'd2;

  localparam logic [15:0] WINDOW_MS_RST   = 16'd100;
  localparam logic [7:0]  TOGGLE_LIM_RST  = 8'd20;
  localparam logic [7:0]  TOGGLE_CNT_MAX  = 8'd255;

  // latch bit positions
  localparam int unsigned LAT_SPEAKER = 0;
  localparam int unsigned LAT_TCH_RST = 1;
  localparam int unsigned LAT_BKLIGHT = 2;

  typedef struct packed {
    logic [7:0]  board_version;
    logic [15:0] window_ms;
    logic [7:0]  toggle_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  reg_addr;
    logic [7:0]  write_data;
    logic        chg_status;
    logic        power_button;
    logic        touch_button;
    logic [11:0] adc_sample;
    logic [31:0] now_ms;
  } in_word_t;

endpackage

// ===== hw/rtl/bior_if.sv =====
// Valid/ready channels for input words and result words.
interface bior_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  reg_addr;
  logic [7:0]  write_data;
  logic        chg_status;
  logic        power_button;
  logic        touch_button;
  logic [11:0] adc_sample;
  logic [31:0] now_ms;

  modport source (output valid, operation, reg_addr, write_data, chg_status,
                  power_button, touch_button, adc_sample, now_ms,
                  input ready);
  modport sink (input valid, operation, reg_addr, write_data, chg_status,
                power_button, touch_button, adc_sample, now_ms,
                output ready);
endinterface

interface bior_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       speaker_enable;
  logic       touch_reset;
  logic       backlight_on;
  logic [7:0] backlight_duty;
  logic       lcd_word_valid;
  logic [8:0] lcd_word;
  logic       battery_connected;
  logic       battery_charging;

  modport source (output valid, read_data, speaker_enable, touch_reset, backlight_on,
                  backlight_duty, lcd_word_valid, lcd_word, battery_connected,
                  battery_charging, input ready);
  modport sink (input valid, read_data, speaker_enable, touch_reset, backlight_on,
                backlight_duty, lcd_word_valid, lcd_word, battery_connected,
                battery_charging, output ready);
endinterface

// ===== hw/rtl/bior_cfg.sv =====
// APB configuration registers.
module bior_cfg
  import bior_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t cfg_r, cfg_nxt;
  logic wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[3:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        CFG_IDX_VERSION: cfg_nxt.board_version = pwdata[7:0];
        CFG_IDX_WINDOW:  cfg_nxt.window_ms     = pwdata[15:0];
        CFG_IDX_LIMIT:   cfg_nxt.toggle_limit  = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.board_version <= 8'd0;
      cfg_r.window_ms     <= WINDOW_MS_RST;
      cfg_r.toggle_limit  <= TOGGLE_LIM_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (idx)
      CFG_IDX_VERSION: prdata = {24'd0, cfg_r.board_version};
      CFG_IDX_WINDOW:  prdata = {16'd0, cfg_r.window_ms};
      CFG_IDX_LIMIT:   prdata = {24'd0, cfg_r.toggle_limit};
      default:         prdata = 32'd0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== hw/rtl/bior_core.sv =====
// Board state, per-word logic and result register.
module bior_core
  import bior_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     word_valid,
  input  in_word_t word,
  output logic     take,
  bior_out_if.source out_ch
);

  logic [7:0]  toggle_count_r, toggle_count_nxt;
  logic        last_pin_r, last_pin_nxt;
  logic [31:0] window_start_r, window_start_nxt;
  logic        connected_r, connected_nxt;
  logic        charging_r, charging_nxt;
  logic [11:0] level_r, level_nxt;
  logic [2:0]  latches_r, latches_nxt;
  logic [7:0]  duty_r, duty_nxt;

  logic [7:0]  rd;
  logic        lv;
  logic [8:0]  lw;
  logic [7:0]  cnt_inc;
  logic [31:0] elapsed;
  logic        data_nz;

  logic        out_valid_r;
  logic [7:0]  rd_r;
  logic        lv_r;
  logic [8:0]  lw_r;

  assign take    = word_valid && (!out_valid_r || out_ch.ready);
  assign elapsed = word.now_ms - window_start_r;
  assign data_nz = |word.write_data;
  assign cnt_inc = ((word.chg_status != last_pin_r) && (toggle_count_r != TOGGLE_CNT_MAX))
                   ? toggle_count_r + 8'd1 : toggle_count_r;

  always_comb begin
    toggle_count_nxt = toggle_count_r;
    last_pin_nxt     = last_pin_r;
    window_start_nxt = window_start_r;
    connected_nxt    = connected_r;
    charging_nxt     = charging_r;
    level_nxt        = level_r;
    latches_nxt      = latches_r;
    duty_nxt         = duty_r;
    rd = 8'd0;
    lv = 1'b0;
    lw = 9'd0;
    case (op_t'(word.operation))
      OP_UPDATE: begin
        toggle_count_nxt = cnt_inc;
        last_pin_nxt     = word.chg_status;
        if (elapsed >= {16'd0, cfg.window_ms}) begin
          window_start_nxt = word.now_ms;
          connected_nxt    = !(cnt_inc > cfg.toggle_limit);
          toggle_count_nxt = 8'd0;
        end
        charging_nxt = connected_nxt && !word.chg_status;
      end
      OP_READ: begin
        case (word.reg_addr)
          ADDR_VERSION:  rd = cfg.board_version;
          ADDR_PWR_BTN:  rd = {7'd0, word.power_button};
          ADDR_CHG_FLAG: rd = {6'd0, connected_r, charging_r};
          ADDR_TCH_BTN:  rd = {7'd0, word.touch_button};
          ADDR_SPEAKER:  rd = {7'd0, latches_r[LAT_SPEAKER]};
          ADDR_TCH_RST:  rd = {7'd0, latches_r[LAT_TCH_RST]};
          ADDR_BKLIGHT:  rd = {7'd0, latches_r[LAT_BKLIGHT]};
          ADDR_PWM_DUTY: rd = duty_r;
          ADDR_ADC_LO:   rd = level_r[7:0];
          ADDR_ADC_HI:   rd = {4'd0, level_r[11:8]};
          default:       rd = 8'd0;
        endcase
      end
      OP_WRITE: begin
        case (word.reg_addr)
          ADDR_SPEAKER:  latches_nxt[LAT_SPEAKER] = data_nz;
          ADDR_TCH_RST:  latches_nxt[LAT_TCH_RST] = data_nz;
          ADDR_BKLIGHT:  latches_nxt[LAT_BKLIGHT] = data_nz;
          ADDR_LCD_CMD: begin
            lv = 1'b1;
            lw = {1'b0, word.write_data};
          end
          ADDR_LCD_DATA: begin
            lv = 1'b1;
            lw = {1'b1, word.write_data};
          end
          ADDR_PWM_DUTY: duty_nxt = word.write_data;
          ADDR_ADC_LAT:  if (data_nz) level_nxt = word.adc_sample;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      toggle_count_r <= 8'd0;
      last_pin_r     <= 1'b0;
      window_start_r <= 32'd0;
      connected_r    <= 1'b0;
      charging_r     <= 1'b0;
      level_r        <= 12'd0;
      latches_r      <= 3'd0;
      duty_r         <= 8'd0;
      out_valid_r    <= 1'b0;
    end else begin
      if (take) begin
        toggle_count_r <= toggle_count_nxt;
        last_pin_r     <= last_pin_nxt;
        window_start_r <= window_start_nxt;
        connected_r    <= connected_nxt;
        charging_r     <= charging_nxt;
        level_r        <= level_nxt;
        latches_r      <= latches_nxt;
        duty_r         <= duty_nxt;
        out_valid_r    <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // per-word result fields; the state fields come straight from the state regs
  always_ff @(posedge clk) begin
    if (take) begin
      rd_r <= rd;
      lv_r <= lv;
      lw_r <= lw;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.read_data         = rd_r;
  assign out_ch.speaker_enable    = latches_r[LAT_SPEAKER];
  assign out_ch.touch_reset       = latches_r[LAT_TCH_RST];
  assign out_ch.backlight_on      = latches_r[LAT_BKLIGHT];
  assign out_ch.backlight_duty    = duty_r;
  assign out_ch.lcd_word_valid    = lv_r;
  assign out_ch.lcd_word          = lw_r;
  assign out_ch.battery_connected = connected_r;
  assign out_ch.battery_charging  = charging_r;

endmodule

// ===== hw/rtl/board_io_register_slave_top.sv =====
// An accepted input word passes the input register, then the result register, before
// its result word is valid. Throughput: one word per cycle while the result side
// takes each result; the input register and the result register let a new word in
// while a finished result waits to be taken.
// Reset (synchronous, rst_n low): state and latches clear, window_ms = 100,
// toggle_limit = 20, board_version = 0; both channels empty.
module board_io_register_slave_top
  import bior_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  bior_in_if.sink           in_ch,
  bior_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t     cfg;
  logic     in_valid_r;
  in_word_t in_word_r;
  logic     take;

  assign in_ch.ready = !in_valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_word_r.operation    <= in_ch.operation;
      in_word_r.reg_addr     <= in_ch.reg_addr;
      in_word_r.write_data   <= in_ch.write_data;
      in_word_r.chg_status   <= in_ch.chg_status;
      in_word_r.power_button <= in_ch.power_button;
      in_word_r.touch_button <= in_ch.touch_button;
      in_word_r.adc_sample   <= in_ch.adc_sample;
      in_word_r.now_ms       <= in_ch.now_ms;
    end
  end

  bior_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bior_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .word_valid (in_valid_r),
    .word       (in_word_r),
    .take       (take),
    .out_ch     (out_ch)
  );

endmodule

// ===== hw/rtl/bior_chk.sv =====
// Port-level checks of the result channel, bound to the top level.
`include "board_io_register_slave_top_defines.svh"

module bior_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] read_data,
  input logic       lcd_word_valid,
  input logic [8:0] lcd_word,
  input logic       battery_connected,
  input logic       battery_charging
);

  `BIOR_AST_NXT(a_out_hold, out_valid && !out_ready, out_valid)
  `BIOR_AST_IMP(a_lcd_idle_zero, out_valid && !lcd_word_valid, lcd_word == 9'd0)
  `BIOR_AST_IMP(a_chg_needs_conn, out_valid && battery_charging, battery_connected)
  `BIOR_AST_IMP(a_lcd_no_read, out_valid && lcd_word_valid, read_data == 8'd0)

endmodule

bind board_io_register_slave_top bior_chk u_bior_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .read_data         (out_ch.read_data),
  .lcd_word_valid    (out_ch.lcd_word_valid),
  .lcd_word          (out_ch.lcd_word),
  .battery_connected (out_ch.battery_connected),
  .battery_charging  (out_ch.battery_charging)
);

// ===== dv/board_io_register_slave_top_test.sv =====
// Self-checking testbench for the board I/O register slave: directed and random words.
module board_io_register_slave_top_test;
  import bior_pkg::*;

  typedef struct packed {
    logic [7:0] read_data;
    logic       speaker_enable;
    logic       touch_reset;
    logic       backlight_on;
    logic [7:0] backlight_duty;
    logic       lcd_word_valid;
    logic [8:0] lcd_word;
    logic       battery_connected;
    logic       battery_charging;
  } board_result_t;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned MAX_PRINTED = 200;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  bior_in_if  in_ch ();
  bior_out_if out_ch ();

  board_io_register_slave_top u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predicted block state and configuration
  logic [7:0]  m_version;
  logic [15:0] m_window;
  logic [7:0]  m_limit;
  logic [7:0]  m_toggles;
  logic        m_last_pin;
  logic [31:0] m_win_start;
  logic        m_connected;
  logic        m_charging;
  logic [11:0] m_batt_level;
  logic [2:0]  m_latches;
  logic [7:0]  m_duty;

  board_result_t pending_results[$];

  int unsigned errors;
  int unsigned words_sent;
  int unsigned results_seen;
  int unsigned cfg_writes;
  int unsigned settings_run;
  int unsigned stall_left;
  bit          calm;
  logic [31:0] clock_ms;
  logic        drive_pin;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned draw_wait();
    return calm ? 0 : $urandom_range(0, 3);
  endfunction

  function automatic board_result_t predict_board_word(input in_word_t w);
    board_result_t r;
    logic [31:0]   elapsed;
    r = '0;
    case (w.operation)
      OP_UPDATE: begin
        if (w.chg_status != m_last_pin && m_toggles != TOGGLE_CNT_MAX)
          m_toggles = m_toggles + 8'd1;
        m_last_pin = w.chg_status;
        elapsed = w.now_ms - m_win_start;
        if (elapsed >= {16'd0, m_window}) begin
          m_win_start = w.now_ms;
          m_connected = !(m_toggles > m_limit);
          m_toggles = '0;
        end
        m_charging = m_connected && !w.chg_status;
      end
      OP_READ: begin
        case (w.reg_addr)
          ADDR_VERSION:  r.read_data = m_version;
          ADDR_PWR_BTN:  r.read_data = {7'd0, w.power_button};
          ADDR_CHG_FLAG: r.read_data = {6'd0, m_connected, m_charging};
          ADDR_TCH_BTN:  r.read_data = {7'd0, w.touch_button};
          ADDR_SPEAKER:  r.read_data = {7'd0, m_latches[LAT_SPEAKER]};
          ADDR_TCH_RST:  r.read_data = {7'd0, m_latches[LAT_TCH_RST]};
          ADDR_BKLIGHT:  r.read_data = {7'd0, m_latches[LAT_BKLIGHT]};
          ADDR_PWM_DUTY: r.read_data = m_duty;
          ADDR_ADC_LO:   r.read_data = m_batt_level[7:0];
          ADDR_ADC_HI:   r.read_data = {4'd0, m_batt_level[11:8]};
          default:       r.read_data = '0;
        endcase
      end
      OP_WRITE: begin
        case (w.reg_addr)
          ADDR_SPEAKER:  m_latches[LAT_SPEAKER] = (w.write_data != 8'd0);
          ADDR_TCH_RST:  m_latches[LAT_TCH_RST] = (w.write_data != 8'd0);
          ADDR_BKLIGHT:  m_latches[LAT_BKLIGHT] = (w.write_data != 8'd0);
          ADDR_LCD_CMD: begin
            r.lcd_word_valid = 1'b1;
            r.lcd_word = {1'b0, w.write_data};
          end
          ADDR_LCD_DATA: begin
            r.lcd_word_valid = 1'b1;
            r.lcd_word = {1'b1, w.write_data};
          end
          ADDR_PWM_DUTY: m_duty = w.write_data;
          ADDR_ADC_LAT:  if (w.write_data != 8'd0) m_batt_level = w.adc_sample;
          default: ;
        endcase
      end
      default: ;
    endcase
    r.speaker_enable    = m_latches[LAT_SPEAKER];
    r.touch_reset       = m_latches[LAT_TCH_RST];
    r.backlight_on      = m_latches[LAT_BKLIGHT];
    r.backlight_duty    = m_duty;
    r.battery_connected = m_connected;
    r.battery_charging  = m_charging;
    return r;
  endfunction

  function automatic in_word_t make_word(input logic [1:0] op, input logic [7:0] addr,
                                         input logic [7:0] data);
    in_word_t w;
    w = '0;
    w.operation  = op;
    w.reg_addr   = addr;
    w.write_data = data;
    w.chg_status = drive_pin;
    w.now_ms     = clock_ms;
    return w;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= MAX_PRINTED)
      $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
  endtask

  task automatic check_result();
    board_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result word with nothing pending", 32'd0, 32'd0);
      return;
    end
    want = pending_results.pop_front();
    results_seen++;
    if (out_ch.read_data !== want.read_data)
      report_mismatch("read_data", 32'(out_ch.read_data), 32'(want.read_data));
    if (out_ch.speaker_enable !== want.speaker_enable)
      report_mismatch("speaker_enable", 32'(out_ch.speaker_enable),
                      32'(want.speaker_enable));
    if (out_ch.touch_reset !== want.touch_reset)
      report_mismatch("touch_reset", 32'(out_ch.touch_reset), 32'(want.touch_reset));
    if (out_ch.backlight_on !== want.backlight_on)
      report_mismatch("backlight_on", 32'(out_ch.backlight_on), 32'(want.backlight_on));
    if (out_ch.backlight_duty !== want.backlight_duty)
      report_mismatch("backlight_duty", 32'(out_ch.backlight_duty),
                      32'(want.backlight_duty));
    if (out_ch.lcd_word_valid !== want.lcd_word_valid)
      report_mismatch("lcd_word_valid", 32'(out_ch.lcd_word_valid),
                      32'(want.lcd_word_valid));
    if (out_ch.lcd_word !== want.lcd_word)
      report_mismatch("lcd_word", 32'(out_ch.lcd_word), 32'(want.lcd_word));
    if (out_ch.battery_connected !== want.battery_connected)
      report_mismatch("battery_connected", 32'(out_ch.battery_connected),
                      32'(want.battery_connected));
    if (out_ch.battery_charging !== want.battery_charging)
      report_mismatch("battery_charging", 32'(out_ch.battery_charging),
                      32'(want.battery_charging));
  endtask

  // result side: random stall drawn after each taken word
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left = 0;
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        check_result();
        stall_left = draw_wait();
      end else if (stall_left != 0) begin
        stall_left--;
      end
      out_ch.ready <= (stall_left == 0);
    end
  end

  // valid is only dropped when a gap follows, so back-to-back words keep it high
  task automatic send_word(input in_word_t w);
    int unsigned gap;
    gap = draw_wait();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.operation    <= w.operation;
    in_ch.reg_addr     <= w.reg_addr;
    in_ch.write_data   <= w.write_data;
    in_ch.chg_status   <= w.chg_status;
    in_ch.power_button <= w.power_button;
    in_ch.touch_button <= w.touch_button;
    in_ch.adc_sample   <= w.adc_sample;
    in_ch.now_ms       <= w.now_ms;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(predict_board_word(w));
    words_sent++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      CFG_IDX_VERSION: m_version = value[7:0];
      CFG_IDX_WINDOW:  m_window  = value[15:0];
      CFG_IDX_LIMIT:   m_limit   = value[7:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic apply_config(input logic [7:0] version, input logic [15:0] window,
                              input logic [7:0] limit);
    drain_results();
    cfg_write(CFG_IDX_VERSION, {24'd0, version});
    cfg_write(CFG_IDX_WINDOW, {16'd0, window});
    cfg_write(CFG_IDX_LIMIT, {24'd0, limit});
    settings_run++;
  endtask

  task automatic test_register_map();
    in_word_t w;
    send_word(make_word(OP_READ, ADDR_VERSION, 8'h00));
    send_word(make_word(OP_WRITE, ADDR_VERSION, 8'hFF));   // read-only, dropped
    send_word(make_word(OP_READ, ADDR_VERSION, 8'h00));
    w = make_word(OP_READ, ADDR_PWR_BTN, 8'h00);
    w.power_button = 1'b1;
    send_word(w);
    send_word(make_word(OP_READ, ADDR_PWR_BTN, 8'h00));
    w = make_word(OP_READ, ADDR_TCH_BTN, 8'h00);
    w.touch_button = 1'b1;
    send_word(w);
    send_word(make_word(OP_WRITE, ADDR_SPEAKER, 8'h01));
    send_word(make_word(OP_WRITE, ADDR_TCH_RST, 8'h80));
    send_word(make_word(OP_WRITE, ADDR_BKLIGHT, 8'hFF));
    send_word(make_word(OP_READ, ADDR_TCH_RST, 8'h00));
    send_word(make_word(OP_WRITE, ADDR_SPEAKER, 8'h00));
    send_word(make_word(OP_READ, ADDR_SPEAKER, 8'h00));
    send_word(make_word(OP_WRITE, ADDR_LCD_CMD, 8'hFF));
    send_word(make_word(OP_WRITE, ADDR_LCD_DATA, 8'h00));
    send_word(make_word(OP_WRITE, ADDR_PWM_DUTY, 8'hFF));
    send_word(make_word(OP_READ, ADDR_PWM_DUTY, 8'h00));
    w = make_word(OP_WRITE, ADDR_ADC_LAT, 8'h00);        // zero write leaves the sample
    w.adc_sample = 12'hFFF;
    send_word(w);
    w.write_data = 8'h01;
    send_word(w);
    send_word(make_word(OP_READ, ADDR_ADC_LO, 8'h00));
    send_word(make_word(OP_READ, ADDR_ADC_HI, 8'h00));
    send_word(make_word(OP_READ, ADDR_LCD_CMD, 8'h00));   // write-only reads zero
    send_word(make_word(OP_READ, 8'hFF, 8'h00));
    send_word(make_word(OP_WRITE, 8'hFF, 8'hFF));
    send_word(make_word(OP_UNUSED, ADDR_PWM_DUTY, 8'h55));
    drive_pin = 1'b1;
    clock_ms = 32'd100;
    send_word(make_word(OP_UPDATE, 8'h00, 8'h00));
    drive_pin = 1'b0;
    clock_ms = 32'd250;
    send_word(make_word(OP_UPDATE, 8'h00, 8'h00));
    send_word(make_word(OP_READ, ADDR_CHG_FLAG, 8'h00));
  endtask

  // elapsed time must wrap modulo 2^32
  task automatic test_window_wrap();
    apply_config(8'hC3, 16'd100, 8'd20);
    clock_ms = 32'hFFFF_FFF0;
    send_word(make_word(OP_UPDATE, 8'h00, 8'h00));
    drive_pin = 1'b1;
    clock_ms = 32'h0000_0040;
    send_word(make_word(OP_UPDATE, 8'h00, 8'h00));
    clock_ms = 32'h0000_0060;
    send_word(make_word(OP_UPDATE, 8'h00, 8'h00));
    send_word(make_word(OP_READ, ADDR_CHG_FLAG, 8'h00));
    apply_config(8'h3C, 16'd1, 8'd0);
    drive_pin = 1'b0;
    send_word(make_word(OP_UPDATE, 8'h00, 8'h00));
    clock_ms = clock_ms + 32'd1;
    send_word(make_word(OP_UPDATE, 8'h00, 8'h00));
    send_word(make_word(OP_READ, ADDR_VERSION, 8'h00));
  endtask

  // more than 255 toggles in one long window; count must hold at 255
  task automatic test_toggle_saturation();
    logic [31:0] base;
    for (int pass = 0; pass < 2; pass++) begin
      apply_config(8'h5A, 16'hFFFF, (pass == 0) ? 8'd255 : 8'd254);
      base = m_win_start + 32'd70000;
      clock_ms = base;
      send_word(make_word(OP_UPDATE, 8'h00, 8'h00));
      clock_ms = base + 32'd100;
      for (int i = 0; i < 300; i++) begin
        drive_pin = ~drive_pin;
        send_word(make_word(OP_UPDATE, 8'h00, 8'h00));
      end
      clock_ms = base + 32'd65535;
      send_word(make_word(OP_UPDATE, 8'h00, 8'h00));
      send_word(make_word(OP_READ, ADDR_CHG_FLAG, 8'h00));
    end
  endtask

  task automatic run_traffic(input int unsigned count, input int unsigned dt_max);
    in_word_t    w;
    int unsigned pick;
    int unsigned toggle_pct;
    toggle_pct = 50;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 50 == 0) calm = ($urandom_range(0, 3) == 0);
      if (i % 32 == 0) toggle_pct = $urandom_range(0, 100);
      if (i == count / 2) drain_results();
      if ($urandom_range(0, 99) == 0)
        clock_ms = $urandom();
      else
        clock_ms = clock_ms + $urandom_range(0, dt_max);
      if ($urandom_range(0, 99) < toggle_pct) drive_pin = ~drive_pin;
      pick = $urandom_range(0, 99);
      w = make_word((pick < 40) ? OP_UPDATE : (pick < 70) ? OP_READ :
                    (pick < 95) ? OP_WRITE : OP_UNUSED,
                    ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 13))
                                                 : 8'($urandom_range(0, 255)),
                    ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom()));
      w.power_button = 1'($urandom());
      w.touch_button = 1'($urandom());
      w.adc_sample   = 12'($urandom_range(0, 4095));
      send_word(w);
    end
    calm = 1'b0;
  endtask

  task automatic test_random_traffic();
    apply_config(8'h00, 16'd1, 8'd0);
    run_traffic(250, 2);
    apply_config(8'hFF, 16'hFFFF, 8'd255);
    run_traffic(250, 3000);
    apply_config(8'hA5, 16'd37, 8'd6);
    run_traffic(250, 4);
    apply_config(8'h96, 16'd100, 8'd8);
    run_traffic(250, 6);
  endtask

  // stops the run when no handshake of any kind happens for too long
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (psel && penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    errors = 0;
    words_sent = 0;
    results_seen = 0;
    cfg_writes = 0;
    settings_run = 1;
    calm = 1'b0;
    clock_ms = '0;
    drive_pin = 1'b0;
    m_version = '0;
    m_window = WINDOW_MS_RST;
    m_limit = TOGGLE_LIM_RST;
    m_toggles = '0;
    m_last_pin = 1'b0;
    m_win_start = '0;
    m_connected = 1'b0;
    m_charging = 1'b0;
    m_batt_level = '0;
    m_latches = '0;
    m_duty = '0;
    rst_n              <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.operation    <= '0;
    in_ch.reg_addr     <= '0;
    in_ch.write_data   <= '0;
    in_ch.chg_status   <= 1'b0;
    in_ch.power_button <= 1'b0;
    in_ch.touch_button <= 1'b0;
    in_ch.adc_sample   <= '0;
    in_ch.now_ms       <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_register_map();
    test_window_wrap();
    test_toggle_saturation();
    test_random_traffic();
    drain_results();

    $display("covered %0d words (register map, window wrap, toggle saturation, random)",
             words_sent);
    $display("checked %0d results over %0d settings with %0d config writes",
             results_seen, settings_run, cfg_writes);
    if (errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
